// File: rtl/core/inversion_counter_macros.svh
// ---------------------------------------------------------------------------
// inversion_counter assertion macros
// Shorthands for the concurrent checks of the inversion counter; they sample
// on clk and are disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef INVERSION_COUNTER_MACROS_SVH
`define INVERSION_COUNTER_MACROS_SVH

// property that must hold at every edge
`define IC_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// when a holds, b must hold in the following cycle
`define IC_IMPLY_NEXT(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);

`endif

// File: rtl/core/ic_pkg.sv
// ---------------------------------------------------------------------------
// ic_pkg
// Shared types and constants of the inversion counter.
// ---------------------------------------------------------------------------
package ic_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 19;
	localparam logic [COUNT_W-1:0] TALLY_MAX = '1;

	// token that walks down the cell chain with each accepted word
	typedef struct packed {
		logic                      valid;
		logic                      last;
		logic                      active; // stored and compared; 0 when dropped
		logic                      ovf;    // sequence lost words (meaningful on last)
		logic signed [VALUE_W-1:0] value;
	} token_t;

endpackage

// File: rtl/core/ic_cell.sv
// ---------------------------------------------------------------------------
// ic_cell
// One chain cell: holds one stored value, counts the passing token when its
// value is strictly greater, and hands the token to the next cell.
// ---------------------------------------------------------------------------
module ic_cell #(
	parameter int INDEX = 0,
	parameter int IDX_W = 10,
	parameter int CNT_W = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  ic_pkg::token_t      tok_in,
	input  logic [IDX_W-1:0]    slot_in,
	input  logic [CNT_W-1:0]    cnt_in,
	output ic_pkg::token_t      tok_out,
	output logic [IDX_W-1:0]    slot_out,
	output logic [CNT_W-1:0]    cnt_out
);

	logic signed [ic_pkg::VALUE_W-1:0] held_q;
	logic                              held_valid_q;
	ic_pkg::token_t                    tok_q;
	logic [IDX_W-1:0]                  slot_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic                              hit;
	logic                              own_slot;

	assign hit = tok_in.valid && tok_in.active && held_valid_q &&
		($signed(held_q) > $signed(tok_in.value));
	assign own_slot = (slot_in == IDX_W'(INDEX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q        <= '0;
			held_valid_q <= 1'b0;
		end else if (adv) begin
			tok_q <= tok_in;
			if (tok_in.valid) begin
				// the last word sweeps the chain clean behind it
				if (tok_in.last)
					held_valid_q <= 1'b0;
				else if (tok_in.active && own_slot)
					held_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slot_q <= slot_in;
			cnt_q  <= cnt_in + CNT_W'(hit);
			if (tok_in.valid && tok_in.active && !tok_in.last && own_slot)
				held_q <= tok_in.value;
		end
	end

	assign tok_out  = tok_q;
	assign slot_out = slot_q;
	assign cnt_out  = cnt_q;

endmodule

// File: rtl/core/ic_tally.sv
// ---------------------------------------------------------------------------
// ic_tally
// Chain end: sums per-word counts with saturation and holds the result word
// until the downstream side takes it.
// ---------------------------------------------------------------------------
module ic_tally #(
	parameter int CNT_W = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ic_pkg::token_t              tok,
	input  logic [CNT_W-1:0]            cnt,
	input  logic                        res_ready,
	output logic                        res_valid,
	output logic [ic_pkg::COUNT_W-1:0]  res_count,
	output logic                        res_ovf,
	output logic                        adv
);

	localparam int SUM_W = ((CNT_W > ic_pkg::COUNT_W) ? CNT_W : ic_pkg::COUNT_W) + 1;

	logic [ic_pkg::COUNT_W-1:0] tally_q;
	logic [ic_pkg::COUNT_W-1:0] res_count_q;
	logic                       res_ovf_q;
	logic                       res_valid_q;
	logic [SUM_W-1:0]           sum_wide;
	logic [ic_pkg::COUNT_W-1:0] sum_sat;

	assign sum_wide = SUM_W'(tally_q) + SUM_W'(cnt);
	assign sum_sat  = (sum_wide > SUM_W'(ic_pkg::TALLY_MAX)) ? ic_pkg::TALLY_MAX :
		sum_wide[ic_pkg::COUNT_W-1:0];

	// whole chain freezes only when a second result arrives on a full output
	assign adv = !(tok.valid && tok.last && res_valid_q && !res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready)
				res_valid_q <= 1'b0;
			if (adv && tok.valid) begin
				if (tok.last) begin
					res_valid_q <= 1'b1;
					tally_q     <= '0;
				end else begin
					tally_q <= sum_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tok.valid && tok.last) begin
			res_count_q <= sum_sat;
			res_ovf_q   <= tok.ovf;
		end
	end

	assign res_valid = res_valid_q;
	assign res_count = res_count_q;
	assign res_ovf   = res_ovf_q;

endmodule

// File: rtl/core/inversion_counter.sv
// ---------------------------------------------------------------------------
// inversion_counter
// Counts pairs where an earlier signed value is strictly greater than a later.
// ---------------------------------------------------------------------------
// Each accepted word enters a chain of MAX_ITEMS cells, picking up one count
// from every earlier stored value that is greater, and stores itself in the
// cell of its position. Words move one cell per cycle and a new word is taken
// every cycle while the chain runs; a last word's result is registered at the
// chain end. The chain stops (tready low) only while a finished result is
// still waiting and the next last word reaches the chain end. Words beyond
// MAX_ITEMS in one sequence are dropped and flagged. The last word clears the
// cells as it passes, so no clearing pass is needed.
module inversion_counter #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	input  logic        s_axis_tlast,  // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [18:0] inversion_count, [19] overflowed
);

	`include "inversion_counter_macros.svh"

	localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W  = IDX_W;
	localparam int FILL_W = $clog2(MAX_ITEMS + 1);

	ic_pkg::token_t   tok   [0:MAX_ITEMS];
	logic [IDX_W-1:0] slot  [0:MAX_ITEMS];
	logic [CNT_W-1:0] cnt   [0:MAX_ITEMS];

	logic [FILL_W-1:0]          fill_q;
	logic                       drop_q;
	logic                       adv;
	logic                       in_fire;
	logic                       room;
	logic [ic_pkg::COUNT_W-1:0] res_count;
	logic                       res_ovf;

	assign room          = (fill_q < FILL_W'(MAX_ITEMS));
	assign s_axis_tready = adv;
	assign in_fire       = s_axis_tvalid && adv;

	assign tok[0] = '{
		valid:  s_axis_tvalid,
		last:   s_axis_tlast,
		active: room,
		ovf:    drop_q || !room,
		value:  s_axis_tdata
	};
	assign slot[0] = fill_q[IDX_W-1:0];
	assign cnt[0]  = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			drop_q <= 1'b0;
		end else if (in_fire) begin
			if (s_axis_tlast) begin
				fill_q <= '0;
				drop_q <= 1'b0;
			end else begin
				fill_q <= fill_q + FILL_W'(room);
				drop_q <= drop_q || !room;
			end
		end
	end

	for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
		ic_cell #(
			.INDEX (k),
			.IDX_W (IDX_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.tok_in   (tok[k]),
			.slot_in  (slot[k]),
			.cnt_in   (cnt[k]),
			.tok_out  (tok[k+1]),
			.slot_out (slot[k+1]),
			.cnt_out  (cnt[k+1])
		);
	end

	ic_tally #(
		.CNT_W (CNT_W)
	) u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok[MAX_ITEMS]),
		.cnt       (cnt[MAX_ITEMS]),
		.res_ready (m_axis_tready),
		.res_valid (m_axis_tvalid),
		.res_count (res_count),
		.res_ovf   (res_ovf),
		.adv       (adv)
	);

	assign m_axis_tdata = {4'd0, res_ovf, res_count};

	`IC_CHECK(a_fill_bound, fill_q <= FILL_W'(MAX_ITEMS), "fill count beyond capacity")
	`IC_IMPLY_NEXT(a_last_clears, in_fire && s_axis_tlast, fill_q == '0 && !drop_q, "sequence state not cleared after last word")
	`IC_CHECK(a_stall_cause, s_axis_tready || (tok[MAX_ITEMS].valid && tok[MAX_ITEMS].last && m_axis_tvalid), "chain stalled without a waiting result")

endmodule

// File: dv/inversion_counter_checker.sv
// ----------------------------------------------------------------------------
// inversion_counter_checker
// Watches both stream ports of the inversion counter, keeps its own tally of
// held values, pair count and dropped words, and compares every total leaving
// the block against the oldest predicted one.
// ----------------------------------------------------------------------------
module inversion_counter_checker #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	input  logic        s_axis_tlast,  // last
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,  // [18:0] inversion_count, [19] overflowed
	output int          errors,
	output int          outstanding,
	output int          totals_checked
);

	typedef struct packed {
		logic [ic_pkg::COUNT_W-1:0] inversions;
		logic                       ovf;
	} total_t;

	total_t                            expected_totals[$];
	logic signed [ic_pkg::VALUE_W-1:0] held [MAX_ITEMS];
	int                                fill;
	int                                tally;
	bit                                dropped;

	function automatic int greater_held(logic signed [ic_pkg::VALUE_W-1:0] v);
		int n;
		n = 0;
		for (int i = 0; i < fill; i++)
			if (held[i] > v)
				n++;
		return n;
	endfunction

	task automatic flag(string what, logic [31:0] exp_val, logic [31:0] got_val);
		errors++;
		if (errors <= 10)
			$display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, what,
				exp_val, got_val);
	endtask

	initial begin
		errors = 0;
		outstanding = 0;
		totals_checked = 0;
		fill = 0;
		tally = 0;
		dropped = 0;
	end

	always @(posedge clk) begin
		total_t exp_total;
		total_t got_total;
		int     sum;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_total.inversions = m_axis_tdata[ic_pkg::COUNT_W-1:0];
				got_total.ovf = m_axis_tdata[ic_pkg::COUNT_W];
				if (expected_totals.size() == 0) begin
					flag("unexpected total word", 32'd0, {8'd0, m_axis_tdata});
				end else begin
					exp_total = expected_totals.pop_front();
					totals_checked++;
					if (got_total.inversions !== exp_total.inversions)
						flag("inversion count", 32'(exp_total.inversions),
							32'(got_total.inversions));
					if (got_total.ovf !== exp_total.ovf)
						flag("overflow flag", 32'(exp_total.ovf), 32'(got_total.ovf));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				// full store: word is neither compared nor kept
				if (fill < MAX_ITEMS) begin
					sum = tally + greater_held(s_axis_tdata);
					tally = (sum > int'(ic_pkg::TALLY_MAX)) ? int'(ic_pkg::TALLY_MAX) : sum;
					held[fill] = s_axis_tdata;
					fill++;
				end else begin
					dropped = 1;
				end
				if (s_axis_tlast) begin
					exp_total.inversions = tally[ic_pkg::COUNT_W-1:0];
					exp_total.ovf = dropped;
					expected_totals.insert(expected_totals.size(), exp_total);
					fill = 0;
					tally = 0;
					dropped = 0;
				end
			end
			outstanding = expected_totals.size();
		end
	end

endmodule

// File: dv/tb_inversion_counter.sv
// ----------------------------------------------------------------------------
// tb_inversion_counter
// Drives runs of signed words into the inversion counter under random and
// forced back-pressure; the checker beside the block judges every total.
// ----------------------------------------------------------------------------
module tb_inversion_counter;

	localparam int DEPTH       = 1024;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;

	int tx_idle_pct;
	int rx_idle_pct;
	bit rx_hold_req;
	int words_sent;
	int runs_sent;
	int errors;
	int outstanding;
	int totals_checked;

	inversion_counter #(.MAX_ITEMS(DEPTH)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	inversion_counter_checker #(.MAX_ITEMS(DEPTH)) chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.errors        (errors),
		.outstanding   (outstanding),
		.totals_checked(totals_checked)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#800000;
		$display("Timed out with %0d totals outstanding", outstanding);
		$display("FAILURE");
		$finish;
	end

	// output side: random stalls, or one long hold-off on request
	initial begin
		m_axis_tready = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 0;
				m_axis_tready <= 0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// mostly small values so ties and inversions are common
	function automatic logic [31:0] rand_value();
		logic [31:0] r;
		case ($urandom_range(9))
			0, 1, 2, 3: r = $urandom_range(16) - 8;
			4, 5: r = $urandom_range(2000) - 1000;
			6: begin
				case ($urandom_range(4))
					0: r = 32'h8000_0000;
					1: r = 32'h7fff_ffff;
					2: r = 32'h0000_0000;
					3: r = 32'hffff_ffff;
					default: r = 32'h0000_0001;
				endcase
			end
			default: r = $urandom;
		endcase
		return r;
	endfunction

	// called and returns at a falling edge
	task automatic send_word(input logic [31:0] v, input bit lst);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= v;
		s_axis_tlast <= lst;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		words_sent++;
		if (lst)
			runs_sent++;
		@(negedge clk);
	endtask

	task automatic send_run(input logic [31:0] vals[$]);
		foreach (vals[i])
			send_word(vals[i], i == vals.size() - 1);
	endtask

	task automatic send_random_runs(input int words);
		int start;
		int len;
		int pick;
		start = words_sent;
		while (words_sent - start < words) begin
			pick = $urandom_range(99);
			if (pick < 70)
				len = $urandom_range(12, 1);
			else if (pick < 95)
				len = $urandom_range(40, 13);
			else
				len = $urandom_range(100, 41);
			for (int i = 0; i < len; i++)
				send_word(rand_value(), i == len - 1);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [31:0] run[$];
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tlast = 0;
		arst_n = 0;
		words_sent = 0;
		runs_sent = 0;
		tx_idle_pct = 21;
		rx_idle_pct = 48;
		rx_hold_req = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// single word, signed extremes both ways, mixed signs, ties, descending
		run = '{32'h0000_0000};
		send_run(run);
		run = '{32'h8000_0000, 32'h7fff_ffff};
		send_run(run);
		run = '{32'h7fff_ffff, 32'h8000_0000};
		send_run(run);
		run = '{32'hffff_ffff, 32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0000};
		send_run(run);
		run = '{32'd7, 32'd7, 32'd7};
		send_run(run);
		run = '{32'd3, 32'd2, 32'd1, 32'd0, 32'hffff_ffff};
		send_run(run);
		wait_drained();

		send_random_runs(250);
		wait_drained();

		// hold the output long enough that a second total backs up the chain
		rx_hold_req = 1;
		send_random_runs(150);
		wait_drained();

		tx_idle_pct = 48;
		rx_idle_pct = 21;
		// strictly descending fill gives the largest count; two words overflow
		for (int i = 0; i < DEPTH + 2; i++)
			send_word((i < DEPTH) ? 32'h7fff_ffff - i : rand_value(), i == DEPTH + 1);
		send_random_runs(150);
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random_runs(200);

		s_axis_tvalid <= 0;
		@(negedge clk);
		for (int n = 0; n < DRAIN_LIMIT && outstanding != 0; n++)
			@(negedge clk);
		repeat (DEPTH + 16) @(negedge clk);

		$display("Sent %0d words in %0d runs, %0d inversion totals compared",
			words_sent, runs_sent, totals_checked);
		$display("Covered ties, signed extremes, full and overflowed store, %0d-cycle hold-off",
			HOLD_CYCLES);
		if (outstanding != 0)
			$display("%0d totals never arrived", outstanding);
		if (errors == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
